[hw/rtl/earc_pkg.sv]
// Package for the rule classifier: transaction types, codes, and rule entry type.
package earc_pkg;

    localparam int TABLE_DEPTH_DEF = 16;

    localparam logic [1:0] CMD_ADD      = 2'd0;
    localparam logic [1:0] CMD_REMOVE   = 2'd1;
    localparam logic [1:0] CMD_CLASSIFY = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;

    localparam logic [15:0] ETYPE_ARP  = 16'h0806;
    localparam logic [15:0] ETYPE_IPV4 = 16'h0800;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [15:0] entry_id;
        logic [1:0]  rule_type;
        logic [15:0] ethertype;
        logic [47:0] eth_src;
        logic [47:0] eth_dst;
        logic [47:0] sender_mac;
        logic [31:0] sender_ip;
        logic [31:0] target_ip;
        logic [31:0] ip_dst;
    } t_in;

    typedef struct packed {
        logic [1:0]  status;
        logic        hit;
        logic [15:0] result_id;
        logic [1:0]  match_kind;
    } t_out;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] proto;
        logic [47:0] src_mac;
        logic [47:0] dst_mac;
        logic [47:0] sender_mac;
        logic [31:0] sender_ip;
        logic [31:0] target_ip;
        logic [31:0] ip_dst;
        logic [15:0] id;
    } t_rule;

    typedef enum logic [1:0] {
        S_IDLE,
        S_PREP,
        S_SCAN
    } t_state;

endpackage

[hw/rtl/earc_cell.sv]
// One rule cell: holds a rule, loads or takes its neighbor's rule, flags a match.
module earc_cell (
    input  logic           i_clk,
    input  logic           i_load,
    input  logic           i_shift,
    input  earc_pkg::t_rule i_new,
    input  earc_pkg::t_rule i_next,
    input  earc_pkg::t_in  i_req,
    output earc_pkg::t_rule o_rule,
    output logic           o_match
);

    earc_pkg::t_rule r_rule;
    logic            r_match;
    logic            n_match;
    logic            kind_hit;
    logic            et_ok;

    always_comb begin
        et_ok = (i_req.ethertype == earc_pkg::ETYPE_ARP) ||
                (i_req.ethertype == earc_pkg::ETYPE_IPV4);
        case (r_rule.kind)
            2'd0: kind_hit = (r_rule.dst_mac == i_req.eth_dst) &&
                             (r_rule.sender_ip == i_req.sender_ip);
            2'd1: kind_hit = (r_rule.dst_mac == i_req.eth_dst) &&
                             (r_rule.src_mac == i_req.eth_src) &&
                             (r_rule.ip_dst != i_req.ip_dst);
            2'd2: kind_hit = (r_rule.src_mac == i_req.eth_src) &&
                             (r_rule.sender_mac == i_req.sender_mac) &&
                             (r_rule.sender_ip == i_req.sender_ip) &&
                             (r_rule.target_ip == i_req.target_ip);
            default: kind_hit = (r_rule.src_mac == i_req.eth_src) &&
                                (r_rule.sender_mac == i_req.sender_mac) &&
                                (r_rule.sender_ip == i_req.sender_ip);
        endcase
        if (i_req.cmd == earc_pkg::CMD_REMOVE) begin
            n_match = (r_rule.id == i_req.entry_id);
        end else begin
            n_match = et_ok && (r_rule.proto == i_req.ethertype) && kind_hit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_match <= n_match;
        if (i_load) begin
            r_rule <= i_new;
        end else if (i_shift) begin
            r_rule <= i_next;
        end
    end

    assign o_rule  = r_rule;
    assign o_match = r_match;

endmodule

[hw/rtl/ethernet_arp_ip_rule_classifier_top.sv]
// Top level of the first-match rule classifier built as a row of rule cells.
// Add and unused commands answer from the idle state; remove and classify first pass
// through a prep state, then scan the cells from index 0 up to the first hit or the rule count.
// Throughput: one transaction at a time; the scan pointer walks one cell per cycle.
// Reset: synchronous active-low; clears rule count, id counter, FSM and output valid.
// Rule contents are not cleared; cells at or above the count are never scanned.
module ethernet_arp_ip_rule_classifier_top #(
    parameter int TABLE_DEPTH = earc_pkg::TABLE_DEPTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  earc_pkg::t_in i_in,
    output logic          o_in_stall,
    output logic          o_out_valid,
    output earc_pkg::t_out o_out,
    input  logic          i_out_stall
);

    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    earc_pkg::t_state r_state, n_state;
    logic [CW-1:0]    r_count, n_count;
    logic [CW-1:0]    r_idx, n_idx;
    logic [15:0]      r_next_id, n_next_id;
    logic             r_out_vld, n_out_vld;
    earc_pkg::t_out   r_out, n_out;
    earc_pkg::t_in    r_req, n_req;

    // Cell row control: one load strobe per cell, one shared shift with its start.
    logic [TABLE_DEPTH-1:0] load_vec;
    logic                   shift_en;
    logic [CW-1:0]          shift_pos;
    earc_pkg::t_rule        new_rule;
    earc_pkg::t_rule        rules [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] match_vec;
    logic                   accept;

    assign o_in_stall  = (r_state != earc_pkg::S_IDLE) || (r_out_vld && i_out_stall);
    assign accept      = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_vld;
    assign o_out       = r_out;

    // New rule formed straight from the incoming add transaction.
    always_comb begin
        new_rule.kind       = i_in.rule_type;
        new_rule.proto      = i_in.ethertype;
        new_rule.src_mac    = i_in.eth_src;
        new_rule.dst_mac    = i_in.eth_dst;
        new_rule.sender_mac = i_in.sender_mac;
        new_rule.sender_ip  = i_in.sender_ip;
        new_rule.target_ip  = i_in.target_ip;
        new_rule.ip_dst     = i_in.ip_dst;
        new_rule.id         = r_next_id;
    end

    genvar g;
    generate
        for (g = 0; g < TABLE_DEPTH; g++) begin : g_cell
            earc_pkg::t_rule next_rule;
            logic            cell_shift;
            if (g == TABLE_DEPTH - 1) begin : g_last
                assign next_rule = rules[g];
            end else begin : g_mid
                assign next_rule = rules[g+1];
            end
            // Close the gap: every cell at or past the removed slot takes its neighbor.
            assign cell_shift = shift_en && (CW'(g) >= shift_pos);
            earc_cell u_cell (
                .i_clk   (i_clk),
                .i_load  (load_vec[g]),
                .i_shift (cell_shift),
                .i_new   (new_rule),
                .i_next  (next_rule),
                .i_req   (r_req),
                .o_rule  (rules[g]),
                .o_match (match_vec[g])
            );
        end
    endgenerate

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_idx     = r_idx;
        n_next_id = r_next_id;
        n_req     = r_req;
        n_out_vld = r_out_vld && i_out_stall;
        n_out     = r_out;
        load_vec  = '0;
        shift_en  = 1'b0;
        shift_pos = r_idx;
        case (r_state)
            earc_pkg::S_IDLE: begin
                if (accept) begin
                    n_req = i_in;
                    n_out = '0;
                    case (i_in.cmd)
                        earc_pkg::CMD_ADD: begin
                            n_out_vld = 1'b1;
                            if (r_count >= CW'(TABLE_DEPTH)) begin
                                n_out.status = earc_pkg::ST_FULL;
                            end else begin
                                load_vec[r_count[IW-1:0]] = 1'b1;
                                n_out.result_id = r_next_id;
                                n_next_id = r_next_id + 16'd1;
                                n_count   = r_count + CW'(1);
                            end
                        end
                        earc_pkg::CMD_REMOVE, earc_pkg::CMD_CLASSIFY: begin
                            // Let the cells register their match flags first.
                            n_idx   = '0;
                            n_state = earc_pkg::S_PREP;
                        end
                        default: begin
                            n_out_vld = 1'b1;
                        end
                    endcase
                end
            end
            earc_pkg::S_PREP: begin
                n_state = earc_pkg::S_SCAN;
            end
            earc_pkg::S_SCAN: begin
                if (r_idx >= r_count) begin
                    // Walked past the last rule without a hit.
                    n_out_vld = 1'b1;
                    if (r_req.cmd == earc_pkg::CMD_REMOVE) begin
                        n_out.status = earc_pkg::ST_NOT_FOUND;
                    end
                    n_state = earc_pkg::S_IDLE;
                end else if (match_vec[r_idx[IW-1:0]]) begin
                    n_out_vld = 1'b1;
                    if (r_req.cmd == earc_pkg::CMD_REMOVE) begin
                        shift_en = 1'b1;
                        n_count  = r_count - CW'(1);
                    end else begin
                        n_out.hit        = 1'b1;
                        n_out.result_id  = rules[r_idx[IW-1:0]].id;
                        n_out.match_kind = rules[r_idx[IW-1:0]].kind;
                    end
                    n_state = earc_pkg::S_IDLE;
                end else begin
                    n_idx = r_idx + CW'(1);
                end
            end
            default: begin
                n_state = earc_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= earc_pkg::S_IDLE;
            r_count   <= '0;
            r_idx     <= '0;
            r_next_id <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_idx     <= n_idx;
            r_next_id <= n_next_id;
            r_out_vld <= n_out_vld;
        end
        r_out <= n_out;
        r_req <= n_req;
    end

    // Rule count never exceeds the table.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(TABLE_DEPTH))
        else $error("rule count above table depth");

    // A scan never overwrites a pending result; this check itself can never fail.
    a_scan_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == earc_pkg::S_SCAN) |-> !(r_out_vld && i_out_stall && n_out_vld &&
        !r_out_vld))
        else $error("scan result collides with pending output");

    // A classify hit always reports ok status.
    a_hit_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out.hit) |-> (r_out.status == earc_pkg::ST_OK))
        else $error("hit with non-ok status");

    // A remove that hits shrinks the table by exactly one.
    a_remove_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        shift_en |=> (r_count == $past(r_count) - CW'(1)))
        else $error("remove did not shrink table");

endmodule

[bench/classifier_checker.sv]
// Checker: watches both channels, predicts each result and compares it.
module classifier_checker (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  earc_pkg::t_in  i_in,
    input  logic           i_in_stall,
    input  logic           i_out_valid,
    input  earc_pkg::t_out i_out,
    input  logic           i_out_stall,
    output int             o_fail_count,
    output int             o_pending
);

    localparam int DEPTH = earc_pkg::TABLE_DEPTH_DEF;

    earc_pkg::t_rule rules[DEPTH];
    int              rule_cnt;
    logic [15:0]     id_ctr;
    earc_pkg::t_out  result_queue[$];

    function automatic logic rule_hits(earc_pkg::t_rule r, earc_pkg::t_in p);
        case (r.kind)
            2'd0: return r.dst_mac == p.eth_dst && r.sender_ip == p.sender_ip;
            2'd1: return r.dst_mac == p.eth_dst && r.src_mac == p.eth_src &&
                         r.ip_dst != p.ip_dst;
            2'd2: return r.src_mac == p.eth_src && r.sender_mac == p.sender_mac &&
                         r.sender_ip == p.sender_ip && r.target_ip == p.target_ip;
            default: return r.src_mac == p.eth_src && r.sender_mac == p.sender_mac &&
                            r.sender_ip == p.sender_ip;
        endcase
    endfunction

    task automatic apply_command(earc_pkg::t_in p);
        earc_pkg::t_out o;
        int             pos;
        o = '0;
        if (p.cmd == earc_pkg::CMD_ADD) begin
            if (rule_cnt >= DEPTH) begin
                o.status = earc_pkg::ST_FULL;
            end else begin
                rules[rule_cnt] = '{p.rule_type, p.ethertype, p.eth_src, p.eth_dst,
                                    p.sender_mac, p.sender_ip, p.target_ip, p.ip_dst,
                                    id_ctr};
                o.result_id = id_ctr;
                id_ctr++;
                rule_cnt++;
            end
        end else if (p.cmd == earc_pkg::CMD_REMOVE) begin
            pos = -1;
            for (int i = 0; i < rule_cnt; i++)
                if (pos < 0 && rules[i].id == p.entry_id) pos = i;
            if (pos < 0) begin
                o.status = earc_pkg::ST_NOT_FOUND;
            end else begin
                for (int i = pos; i + 1 < rule_cnt; i++) rules[i] = rules[i + 1];
                rule_cnt--;
            end
        end else if (p.cmd == earc_pkg::CMD_CLASSIFY) begin
            if (p.ethertype == earc_pkg::ETYPE_ARP || p.ethertype == earc_pkg::ETYPE_IPV4) begin
                for (int i = 0; i < rule_cnt; i++) begin
                    if (!o.hit && rules[i].proto == p.ethertype &&
                        rule_hits(rules[i], p)) begin
                        o.hit        = 1'b1;
                        o.result_id  = rules[i].id;
                        o.match_kind = rules[i].kind;
                    end
                end
            end
        end
        result_queue = {result_queue, o};
    endtask

    always @(posedge i_clk) begin
        earc_pkg::t_out want;
        if (!i_rst_n) begin
            rule_cnt     = 0;
            id_ctr       = '0;
            o_fail_count = 0;
            result_queue.delete();
        end else begin
            // Compare first: the result of a transaction cannot leave in its own cycle.
            if (i_out_valid && !i_out_stall) begin
                if (result_queue.size() == 0) begin
                    $display("%0t unexpected result %h", $time, i_out);
                    o_fail_count++;
                end else begin
                    want = result_queue.pop_front();
                    if (want.status !== i_out.status || want.hit !== i_out.hit ||
                        want.result_id !== i_out.result_id ||
                        want.match_kind !== i_out.match_kind) begin
                        $display("%0t mismatch expected %h actual %h", $time, want, i_out);
                        o_fail_count++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) apply_command(i_in);
        end
        o_pending = result_queue.size();
    end
endmodule

[bench/testbench.sv]
// Testbench top: drives commands into the classifier and reports the verdict.
module testbench;

    logic           clk = 1'b0;
    logic           rst_n = 1'b0;
    logic           in_valid = 1'b0;
    earc_pkg::t_in  in_data = '0;
    logic           in_stall;
    logic           out_valid;
    earc_pkg::t_out out_data;
    logic           out_stall = 1'b0;
    int             fail_count;
    int             pending;
    int             cycle_count = 0;
    int             send_idle_pct = 0;
    int             recv_stall_pct = 0;

    // Small address pools so that classify frames hit stored rules often.
    logic [47:0] mac_pool[4];
    logic [31:0] ip_pool[4];
    logic [15:0] live_ids[$];

    always #4 clk = ~clk;

    ethernet_arp_ip_rule_classifier_top u_top (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .i_in(in_data), .o_in_stall(in_stall),
        .o_out_valid(out_valid), .o_out(out_data), .i_out_stall(out_stall)
    );

    classifier_checker u_checker (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .i_in(in_data), .i_in_stall(in_stall),
        .i_out_valid(out_valid), .i_out(out_data), .i_out_stall(out_stall),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // Stall the result channel at the rate of the current phase.
    always @(posedge clk) begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // Hard stop well past the slowest correct run.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 600000) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic logic [47:0] pick_mac();
        if ($urandom_range(3) == 0) return 48'({$urandom, $urandom});
        return mac_pool[$urandom_range(3)];
    endfunction

    function automatic logic [31:0] pick_ip();
        if ($urandom_range(3) == 0) return $urandom;
        return ip_pool[$urandom_range(3)];
    endfunction

    function automatic logic [15:0] pick_etype();
        int r;
        r = $urandom_range(9);
        if (r < 5) return earc_pkg::ETYPE_ARP;
        if (r < 9) return earc_pkg::ETYPE_IPV4;
        return 16'($urandom);
    endfunction

    function automatic earc_pkg::t_in make_item(logic [1:0] cmd);
        earc_pkg::t_in p;
        p.cmd        = cmd;
        p.entry_id   = 16'($urandom);
        p.rule_type  = 2'($urandom);
        p.ethertype  = pick_etype();
        p.eth_src    = pick_mac();
        p.eth_dst    = pick_mac();
        p.sender_mac = pick_mac();
        p.sender_ip  = pick_ip();
        p.target_ip  = pick_ip();
        p.ip_dst     = pick_ip();
        return p;
    endfunction

    // Present one transaction and hold it until accepted; idle first at random.
    task automatic send(earc_pkg::t_in p);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= p;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    logic [15:0] next_guess = '0;

    task automatic send_random();
        earc_pkg::t_in p;
        int            r, k;
        r = $urandom_range(99);
        if (r < 30) p = make_item(earc_pkg::CMD_ADD);
        else if (r < 50) p = make_item(earc_pkg::CMD_REMOVE);
        else if (r < 97) p = make_item(earc_pkg::CMD_CLASSIFY);
        else p = make_item(2'd3);
        if (p.cmd == earc_pkg::CMD_REMOVE && live_ids.size() > 0 &&
            $urandom_range(4) != 0) begin
            k = $urandom_range(live_ids.size() - 1);
            p.entry_id = live_ids[k];
            live_ids.delete(k);
        end
        if (p.cmd == earc_pkg::CMD_ADD && live_ids.size() < earc_pkg::TABLE_DEPTH_DEF) begin
            live_ids = {live_ids, next_guess};
            next_guess++;
        end
        send(p);
    endtask

    initial begin
        earc_pkg::t_in p;
        for (int i = 0; i < 4; i++) begin
            mac_pool[i] = 48'({$urandom, $urandom});
            ip_pool[i]  = $urandom;
        end
        mac_pool[0] = '1;
        ip_pool[0]  = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty-table classify and remove, unused code, fill past full.
        p = make_item(earc_pkg::CMD_CLASSIFY); p.ethertype = earc_pkg::ETYPE_ARP; send(p);
        p = make_item(earc_pkg::CMD_REMOVE); p.entry_id = 16'hFFFF; send(p);
        p = '1; p.cmd = 2'd3; send(p);
        for (int i = 0; i < 17; i++) begin
            p = make_item(earc_pkg::CMD_ADD);
            p.rule_type = i[1:0];
            p.ethertype = i[0] ? earc_pkg::ETYPE_IPV4 : earc_pkg::ETYPE_ARP;
            if (i == 16) p = '1;
            if (i == 16) p.cmd = earc_pkg::CMD_ADD;
            send(p);
        end
        next_guess = 16;
        for (int i = 0; i < 16; i++) live_ids = {live_ids, 16'(i)};
        // Classify with all-ones fields and an unknown ethertype, then remove the middle.
        p = '1; p.cmd = earc_pkg::CMD_CLASSIFY; send(p);
        p = '0; p.cmd = earc_pkg::CMD_CLASSIFY; p.ethertype = 16'h86DD; send(p);
        p = make_item(earc_pkg::CMD_REMOVE); p.entry_id = 16'd7; send(p);
        live_ids.delete(7);

        // Random phases: none, sender idle, receiver stall, both.
        for (int phase = 0; phase < 4; phase++) begin
            send_idle_pct  = (phase == 1) ? 55 : (phase == 3) ? 22 : 0;
            recv_stall_pct = (phase == 2) ? 55 : (phase == 3) ? 22 : 0;
            for (int n = 0; n < 425; n++) send_random();
        end
        in_valid <= 1'b0;

        while (pending != 0) @(posedge clk);
        repeat (40) @(posedge clk);
        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule
